// ===== rtl/zst_pkg.sv =====
`timescale 1ns / 1ps

package zst_pkg;

    // Default configuration of the tracker.
    localparam int INDEX_BITS_DEF  = 24;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int EVQ_DEPTH_DEF   = 4;

    // Threshold register, unsigned Q15.16 magnitude.
    localparam int                 THR_BITS  = 31;
    localparam logic [THR_BITS-1:0] THR_RESET = 31'd32768;

    // Register map, one 32-bit register per word.
    localparam int          PADDR_BITS = 3;
    localparam logic        REG_THRESHOLD = 1'b0;

    // Swing direction, also the encoding of the marker and turning fields.
    typedef logic signed [1:0] t_dir;
    localparam t_dir DIR_NONE = 2'sb00;
    localparam t_dir DIR_UP   = 2'sb01;
    localparam t_dir DIR_DOWN = 2'sb11;

    // One record of an event. pos_cur selects the index of the sample that
    // caused the event; otherwise the record targets the old extreme's index.
    typedef struct packed {
        logic pos_cur;
        logic marker_valid;
        t_dir marker;
        t_dir turning;
    } t_rec;

    localparam int MAX_RECS = 3;

    // Event handed from the front to the back: one to three records.
    typedef struct packed {
        logic [1:0]            cnt;
        t_rec [MAX_RECS-1:0]   rec;
    } t_event;

endpackage

// ===== rtl/zst_front.sv =====
`timescale 1ns / 1ps

module zst_front #(
    parameter int INDEX_BITS  = zst_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = zst_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [SAMPLE_BITS-1:0] i_price,
    input  logic                          i_final_sample,
    input  logic [zst_pkg::THR_BITS-1:0]  i_threshold,
    output logic                          o_push,
    output zst_pkg::t_event               o_event,
    output logic [INDEX_BITS-1:0]         o_idx_ext,
    output logic [INDEX_BITS-1:0]         o_idx_cur
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int CMP_W  = (DIFF_W > zst_pkg::THR_BITS) ? DIFF_W : zst_pkg::THR_BITS;
    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

    zst_pkg::t_dir                 r_dir, n_dir;
    logic signed [SAMPLE_BITS-1:0] r_ext_val, n_ext_val;
    logic [INDEX_BITS-1:0]         r_ext_idx, n_ext_idx;
    logic [INDEX_BITS-1:0]         r_count, n_count;
    logic                          r_seen, n_seen;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic                     diff_neg;
    logic                     diff_zero;
    logic                     big_move;
    zst_pkg::t_event          ev;
    logic                     moved;

    // One subtract serves every direction: the magnitude of the sample's
    // distance from the extreme is what each reversal test needs.
    assign diff      = DIFF_W'(i_price) - DIFF_W'(r_ext_val);
    assign diff_neg  = diff[DIFF_W-1];
    assign diff_zero = (diff == '0);
    assign mag       = diff_neg ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign big_move  = (CMP_W'(mag) >= CMP_W'(i_threshold));

    always_comb begin
        logic [1:0] k;
        k         = 2'd0;
        ev        = '0;
        moved     = 1'b0;
        n_dir     = r_dir;
        n_ext_val = r_ext_val;
        n_ext_idx = r_ext_idx;
        n_seen    = r_seen;
        n_count   = (r_count == IDX_MAX) ? r_count : r_count + 1'b1;

        if (!r_seen) begin
            n_seen = 1'b1;
            moved  = 1'b1;
        end else if (r_dir == zst_pkg::DIR_NONE) begin
            if (big_move) begin
                n_dir = (!diff_neg && !diff_zero) ? zst_pkg::DIR_UP : zst_pkg::DIR_DOWN;
                moved = 1'b1;
                ev.rec[k] = '{pos_cur: 1'b1, marker_valid: 1'b1,
                              marker: n_dir, turning: n_dir};
                k = k + 2'd1;
            end
        end else if (r_dir == zst_pkg::DIR_UP) begin
            if (!diff_neg) begin
                moved = 1'b1;
            end else if (big_move) begin
                n_dir = zst_pkg::DIR_DOWN;
                moved = 1'b1;
                ev.rec[k] = '{pos_cur: 1'b0, marker_valid: 1'b1,
                              marker: zst_pkg::DIR_UP, turning: zst_pkg::DIR_UP};
                k = k + 2'd1;
                ev.rec[k] = '{pos_cur: 1'b1, marker_valid: 1'b0,
                              marker: zst_pkg::DIR_NONE, turning: zst_pkg::DIR_DOWN};
                k = k + 2'd1;
            end
        end else begin
            if (diff_neg || diff_zero) begin
                moved = 1'b1;
            end else if (big_move) begin
                n_dir = zst_pkg::DIR_UP;
                moved = 1'b1;
                ev.rec[k] = '{pos_cur: 1'b0, marker_valid: 1'b1,
                              marker: zst_pkg::DIR_DOWN, turning: zst_pkg::DIR_DOWN};
                k = k + 2'd1;
                ev.rec[k] = '{pos_cur: 1'b1, marker_valid: 1'b0,
                              marker: zst_pkg::DIR_NONE, turning: zst_pkg::DIR_UP};
                k = k + 2'd1;
            end
        end

        if (moved) begin
            n_ext_val = i_price;
            n_ext_idx = r_count;
        end

        // The last sample of a series flushes the extreme as it stands now
        // and returns the tracker to its starting state.
        if (i_final_sample) begin
            ev.rec[k] = '{pos_cur: moved, marker_valid: 1'b1,
                          marker: (n_dir == zst_pkg::DIR_UP) ? zst_pkg::DIR_UP
                                                             : zst_pkg::DIR_DOWN,
                          turning: n_dir};
            k = k + 2'd1;
            n_dir     = zst_pkg::DIR_NONE;
            n_ext_val = '0;
            n_ext_idx = '0;
            n_count   = '0;
            n_seen    = 1'b0;
        end

        ev.cnt = k;
    end

    assign o_event   = ev;
    assign o_push    = i_accept && (ev.cnt != 2'd0);
    assign o_idx_ext = r_ext_idx;
    assign o_idx_cur = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir     <= zst_pkg::DIR_NONE;
            r_ext_val <= '0;
            r_ext_idx <= '0;
            r_count   <= '0;
            r_seen    <= 1'b0;
        end else if (i_accept) begin
            r_dir     <= n_dir;
            r_ext_val <= n_ext_val;
            r_ext_idx <= n_ext_idx;
            r_count   <= n_count;
            r_seen    <= n_seen;
        end
    end

endmodule

// ===== rtl/zst_evq.sv =====
`timescale 1ns / 1ps

module zst_evq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = zst_pkg::EVQ_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
        next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (do_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/zst_back.sv =====
`timescale 1ns / 1ps

module zst_back #(
    parameter int INDEX_BITS = zst_pkg::INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_head_valid,
    input  zst_pkg::t_event       i_head,
    input  logic [INDEX_BITS-1:0] i_head_ext,
    input  logic [INDEX_BITS-1:0] i_head_cur,
    output logic                  o_head_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [INDEX_BITS-1:0] o_position,
    output logic                  o_marker_valid,
    output zst_pkg::t_dir         o_marker,
    output zst_pkg::t_dir         o_turning,
    output logic                  o_run_end
);

    logic [1:0]  r_slot;
    logic        r_out_valid;
    zst_pkg::t_rec rec;
    logic        last;
    logic        load;

    assign rec        = i_head.rec[r_slot];
    assign last       = (r_slot == 2'(i_head.cnt - 2'd1));
    assign load       = i_head_valid && (!r_out_valid || i_pop);
    assign o_head_pop = load && last;
    assign o_empty    = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_slot      <= last ? 2'd0 : r_slot + 2'd1;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_position     <= rec.pos_cur ? i_head_cur : i_head_ext;
            o_marker_valid <= rec.marker_valid;
            o_marker       <= rec.marker;
            o_turning      <= rec.turning;
            o_run_end      <= last;
        end
    end

endmodule

// ===== rtl/zigzag_swing_tracker.sv =====
`timescale 1ns / 1ps

// A sample's first record passes the event queue and then the output register on its way
// to the result ports. Throughput: one sample per cycle on input while the queue has room;
// records leave one per cycle while the host pops, so a reversal (two records) or a reversal
// plus flush (three) holds the result side until all its records have left. The event queue
// between tracker and record expander sets how long input keeps flowing while pop is low.
// Reset is synchronous, active low: series state and queues clear, the threshold is 0.5.

module zigzag_swing_tracker #(
    parameter int INDEX_BITS  = zst_pkg::INDEX_BITS_DEF,
    parameter int SAMPLE_BITS = zst_pkg::SAMPLE_BITS_DEF,
    parameter int EVQ_DEPTH   = zst_pkg::EVQ_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Sample side.
    input  logic                             push,
    output logic                             full,
    input  logic signed [SAMPLE_BITS-1:0]    i_price,
    input  logic                             i_final_sample,
    // Record side.
    output logic                             empty,
    input  logic                             pop,
    output logic [INDEX_BITS-1:0]            o_position,
    output logic                             o_marker_valid,
    output logic signed [1:0]                o_marker,
    output logic signed [1:0]                o_turning,
    output logic                             o_run_end,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [zst_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    // Each queue entry holds the event description and both indices that its
    // records may target: the old extreme's index and the current sample's.
    localparam int EV_W = $bits(zst_pkg::t_event) + 2 * INDEX_BITS;

    logic [zst_pkg::THR_BITS-1:0] r_threshold;
    logic                         cfg_wr;
    logic                         accept;

    zst_pkg::t_event       fe_event;
    logic [INDEX_BITS-1:0] fe_idx_ext;
    logic [INDEX_BITS-1:0] fe_idx_cur;
    logic                  fe_push;

    logic [EV_W-1:0]       q_head;
    logic                  q_empty;
    logic                  q_pop;
    zst_pkg::t_event       hd_event;
    logic [INDEX_BITS-1:0] hd_idx_ext;
    logic [INDEX_BITS-1:0] hd_idx_cur;

    // The port never waits. Only word address zero holds a register; the
    // upper word is read as zero and writes to it are dropped.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == zst_pkg::REG_THRESHOLD) ? {1'b0, r_threshold} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= zst_pkg::THR_RESET;
        end else if (cfg_wr && (paddr[2] == zst_pkg::REG_THRESHOLD)) begin
            r_threshold <= pwdata[zst_pkg::THR_BITS-1:0];
        end
    end

    // A sample is taken whenever the event queue has room. Samples that cause
    // no record update the tracker and leave the queue alone, so a quiet
    // stream flows at one sample per cycle as long as the queue is not full.
    assign accept = push && !full;

    zst_front #(
        .INDEX_BITS  (INDEX_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_price        (i_price),
        .i_final_sample (i_final_sample),
        .i_threshold    (r_threshold),
        .o_push         (fe_push),
        .o_event        (fe_event),
        .o_idx_ext      (fe_idx_ext),
        .o_idx_cur      (fe_idx_cur)
    );

    zst_evq #(
        .WIDTH (EV_W),
        .DEPTH (EVQ_DEPTH)
    ) u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  ({fe_event, fe_idx_ext, fe_idx_cur}),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_full  (full),
        .o_empty (q_empty)
    );

    assign {hd_event, hd_idx_ext, hd_idx_cur} = q_head;

    // The back end walks the head event into an output register, one record per cycle
    // while it is empty or popped, and reloads it in the same cycle that the host pops it.
    zst_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (!q_empty),
        .i_head         (hd_event),
        .i_head_ext     (hd_idx_ext),
        .i_head_cur     (hd_idx_cur),
        .o_head_pop     (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_position     (o_position),
        .o_marker_valid (o_marker_valid),
        .o_marker       (o_marker),
        .o_turning      (o_turning),
        .o_run_end      (o_run_end)
    );

endmodule

// ===== rtl/zst_checker.sv =====
`timescale 1ns / 1ps

module zst_checker #(
    parameter int INDEX_BITS = zst_pkg::INDEX_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input logic [INDEX_BITS-1:0] o_position,
    input logic                  o_marker_valid,
    input logic signed [1:0]     o_marker,
    input logic signed [1:0]     o_turning
);

    // Reset drains both the event queue and the output register.
    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not drained by reset");

    // A record that is not taken stays on the ports unchanged.
    a_record_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_position) && $stable(o_marker_valid)
                           && $stable(o_marker) && $stable(o_turning))
        else $error("waiting record changed");

    // A record without a marker is the turn record of a reversal: it carries
    // a zero marker and a real direction.
    a_turn_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_marker_valid |-> o_marker == 2'sb00 && o_turning != 2'sb00)
        else $error("malformed turn record");

    // Marked records always name a peak or a trough.
    a_marker_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_marker_valid |-> o_marker == 2'sb01 || o_marker == 2'sb11)
        else $error("marker is neither peak nor trough");

endmodule

bind zigzag_swing_tracker zst_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_zst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_position     (o_position),
    .o_marker_valid (o_marker_valid),
    .o_marker       (o_marker),
    .o_turning      (o_turning)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int IDX_W    = zst_pkg::INDEX_BITS_DEF;
    localparam int SMP_W    = zst_pkg::SAMPLE_BITS_DEF;
    // One in Q16.16.
    localparam int Q_ONE    = 65536;
    // The threshold register sits at word 0; the next word maps to nothing.
    localparam logic [zst_pkg::PADDR_BITS-1:0] ADDR_THRESHOLD =
        zst_pkg::PADDR_BITS'(4 * zst_pkg::REG_THRESHOLD);
    localparam logic [zst_pkg::PADDR_BITS-1:0] ADDR_UNMAPPED  =
        ADDR_THRESHOLD + zst_pkg::PADDR_BITS'(4);
    // Cycles to let a sample with no record clear the pipeline before a register write.
    localparam int HOLD_OFF = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [IDX_W-1:0] position;
        logic             marker_valid;
        zst_pkg::t_dir    marker;
        zst_pkg::t_dir    turning;
        logic             run_end;
    } t_swing_rec;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic signed [SMP_W-1:0]        price_in = '0;
    logic                           final_in = 1'b0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [IDX_W-1:0]               position_out;
    logic                           marker_valid_out;
    logic signed [1:0]              marker_out;
    logic signed [1:0]              turning_out;
    logic                           run_end_out;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [zst_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    // Expected records in arrival order.
    t_swing_rec pending_records[$];
    int         errors = 0;
    int         send_idle_pct = 0;
    int         pop_stall_pct = 0;
    int         quiet_cycles = 0;

    // Software copy of the tracker state and its threshold.
    zst_pkg::t_dir                trk_dir = zst_pkg::DIR_NONE;
    longint                       trk_ext_val = 0;
    logic [IDX_W-1:0]             trk_ext_idx = '0;
    logic [IDX_W-1:0]             trk_next_idx = '0;
    logic                         trk_started = 1'b0;
    logic [zst_pkg::THR_BITS-1:0] trk_threshold = zst_pkg::THR_RESET;

    zigzag_swing_tracker DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .push           (push),
        .full           (full),
        .i_price        (price_in),
        .i_final_sample (final_in),
        .empty          (empty),
        .pop            (pop),
        .o_position     (position_out),
        .o_marker_valid (marker_valid_out),
        .o_marker       (marker_out),
        .o_turning      (turning_out),
        .o_run_end      (run_end_out),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, what);
        end
    endtask

    function automatic t_swing_rec make_rec(input logic [IDX_W-1:0] pos, input logic valid,
                                            input zst_pkg::t_dir mark,
                                            input zst_pkg::t_dir turn);
        t_swing_rec r;
        r.position     = pos;
        r.marker_valid = valid;
        r.marker       = mark;
        r.turning      = turn;
        r.run_end      = 1'b0;
        return r;
    endfunction

    // Advances the tracker copy by one sample and queues the records it produces.
    task automatic track_sample(input logic signed [SMP_W-1:0] price, input logic fin);
        t_swing_rec       recs[3];
        int               n;
        logic [IDX_W-1:0] idx;
        longint           p;
        longint           gap;
        longint           thr;
        n   = 0;
        p   = longint'(price);
        thr = longint'(trk_threshold);
        idx = trk_next_idx;
        if (trk_next_idx != '1) begin
            trk_next_idx = trk_next_idx + 1'b1;
        end
        gap = (p >= trk_ext_val) ? p - trk_ext_val : trk_ext_val - p;

        if (!trk_started) begin
            trk_started = 1'b1;
            trk_ext_idx = idx;
            trk_ext_val = p;
        end else if (trk_dir == zst_pkg::DIR_NONE) begin
            if (gap >= thr) begin
                trk_dir     = (p > trk_ext_val) ? zst_pkg::DIR_UP : zst_pkg::DIR_DOWN;
                trk_ext_idx = idx;
                trk_ext_val = p;
                recs[n] = make_rec(idx, 1'b1, trk_dir, trk_dir);
                n++;
            end
        end else if (trk_dir == zst_pkg::DIR_UP) begin
            if (p >= trk_ext_val) begin
                trk_ext_idx = idx;
                trk_ext_val = p;
            end else if (gap >= thr) begin
                // The old high is confirmed as a peak, and the swing turns down here.
                recs[n] = make_rec(trk_ext_idx, 1'b1, zst_pkg::DIR_UP, zst_pkg::DIR_UP);
                n++;
                recs[n] = make_rec(idx, 1'b0, zst_pkg::DIR_NONE, zst_pkg::DIR_DOWN);
                n++;
                trk_dir     = zst_pkg::DIR_DOWN;
                trk_ext_idx = idx;
                trk_ext_val = p;
            end
        end else begin
            if (p <= trk_ext_val) begin
                trk_ext_idx = idx;
                trk_ext_val = p;
            end else if (gap >= thr) begin
                recs[n] = make_rec(trk_ext_idx, 1'b1, zst_pkg::DIR_DOWN, zst_pkg::DIR_DOWN);
                n++;
                recs[n] = make_rec(idx, 1'b0, zst_pkg::DIR_NONE, zst_pkg::DIR_UP);
                n++;
                trk_dir     = zst_pkg::DIR_UP;
                trk_ext_idx = idx;
                trk_ext_val = p;
            end
        end

        // The last sample of a series flushes the running extreme and clears the series.
        if (fin) begin
            recs[n] = make_rec(trk_ext_idx, 1'b1,
                               (trk_dir == zst_pkg::DIR_UP) ? zst_pkg::DIR_UP
                                                            : zst_pkg::DIR_DOWN,
                               trk_dir);
            n++;
            trk_dir      = zst_pkg::DIR_NONE;
            trk_ext_val  = 0;
            trk_ext_idx  = '0;
            trk_next_idx = '0;
            trk_started  = 1'b0;
        end

        if (n > 0) begin
            recs[n-1].run_end = 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            pending_records.push_back(recs[k]);
        end
    endtask

    // Offers one item and returns at the edge where it was taken; push stays high.
    task automatic offer_sample(input logic signed [SMP_W-1:0] price, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push     <= 1'b1;
        price_in <= price;
        final_in <= fin;
        do @(posedge clk); while (full);
        track_sample(price, fin);
    endtask

    // Stops offering items and waits until every expected record has arrived.
    task automatic pause_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_records.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic settle();
        pause_until_drained();
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    // Writes a register, then reads the threshold back and checks it.
    task automatic program_threshold(input logic [zst_pkg::PADDR_BITS-1:0] addr,
                                     input logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_THRESHOLD) begin
            trk_threshold = word[zst_pkg::THR_BITS-1:0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_THRESHOLD;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {1'b0, trk_threshold}) begin
            report_mismatch($sformatf("threshold readback: expected %h, got %h",
                                      {1'b0, trk_threshold}, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Runs at the reset threshold of one half: a lone final sample flushes with no
    // direction, then a series with a sub-threshold wiggle, an up swing, a peak, a
    // trough found at exactly the threshold and a flush at the largest price.
    task automatic test_basic_swings();
        offer_sample('0, 1'b1);
        offer_sample(Q_ONE, 1'b0);
        offer_sample(Q_ONE + Q_ONE / 4, 1'b0);
        offer_sample(2 * Q_ONE, 1'b0);
        offer_sample(3 * Q_ONE, 1'b0);
        offer_sample(2 * Q_ONE + Q_ONE / 4, 1'b0);
        offer_sample(Q_ONE, 1'b0);
        offer_sample(Q_ONE + Q_ONE / 2, 1'b0);
        offer_sample(32'sh7FFF_FFFF, 1'b1);
    endtask

    // Full-scale moves, where the difference needs 33 bits, and a reversal that lands
    // on the final sample so one item causes three records.
    task automatic test_extreme_prices();
        offer_sample(32'sh8000_0000, 1'b0);
        offer_sample(32'sh7FFF_FFFF, 1'b0);
        offer_sample(32'sh8000_0000, 1'b0);
        offer_sample('0, 1'b1);
        offer_sample('0, 1'b0);
        offer_sample(-Q_ONE, 1'b0);
        offer_sample(-2 * Q_ONE, 1'b1);
    endtask

    // With a zero threshold an equal sample already starts a down swing.
    task automatic test_zero_threshold();
        settle();
        program_threshold(ADDR_THRESHOLD, 32'd0);
        offer_sample(5 * Q_ONE, 1'b0);
        offer_sample(5 * Q_ONE, 1'b0);
        offer_sample(5 * Q_ONE, 1'b0);
        offer_sample(5 * Q_ONE, 1'b1);
    endtask

    // The top bit of the write data lies outside the register and must be dropped.
    task automatic test_max_threshold();
        settle();
        program_threshold(ADDR_THRESHOLD, 32'hFFFF_FFFF);
        offer_sample(32'sh8000_0000, 1'b0);
        offer_sample(32'sh7FFF_FFFF, 1'b0);
        offer_sample(32'sh8000_0000, 1'b1);
    endtask

    // A write to an address past the register list leaves the threshold alone.
    task automatic test_unmapped_register();
        settle();
        program_threshold(ADDR_THRESHOLD, 32'd32768);
        program_threshold(ADDR_UNMAPPED, 32'd0);
        offer_sample(Q_ONE, 1'b0);
        offer_sample(Q_ONE + Q_ONE / 4, 1'b1);
    endtask

    // A reversal, then the sender holds off until the result side has caught up.
    task automatic test_pause_for_drain();
        send_idle_pct = 0;
        offer_sample(Q_ONE, 1'b0);
        offer_sample(4 * Q_ONE, 1'b0);
        offer_sample(-4 * Q_ONE, 1'b0);
        pause_until_drained();
        offer_sample(4 * Q_ONE, 1'b0);
        offer_sample(-4 * Q_ONE, 1'b1);
    endtask

    // Mostly random walks whose steps are sized against the threshold, so that swings
    // both pass and miss it; some series lose their final flag, and some items are
    // plain noise over the whole price range.
    task automatic test_random_traffic(input int idle, input int stall,
                                       input logic [31:0] thr_word, input int items);
        int     sent;
        int     len;
        logic   broken;
        longint p;
        longint span;
        longint mag;
        settle();
        program_threshold(ADDR_THRESHOLD, thr_word);
        send_idle_pct = idle;
        pop_stall_pct = stall;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(7) == 0) begin
                offer_sample($urandom, 1'($urandom_range(1)));
                sent++;
            end else begin
                len    = $urandom_range(1, 24);
                broken = ($urandom_range(3) == 0);
                p      = longint'(int'($urandom));
                for (int k = 0; k < len; k++) begin
                    span = (trk_threshold == '0) ? 64'sd16 : 2 * longint'(trk_threshold);
                    mag  = longint'($urandom) % (span + 1);
                    p    = ($urandom_range(1) == 1) ? p + mag : p - mag;
                    if (p > 64'sd2147483647) begin
                        p = 64'sd2147483647;
                    end else if (p < -64'sd2147483648) begin
                        p = -64'sd2147483648;
                    end
                    offer_sample(p[SMP_W-1:0], (k == len - 1) && !broken);
                    sent++;
                end
            end
        end
    endtask

    // The receiver pops at random according to the current stall rate.
    always @(posedge clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // Compares every record taken from the block with the oldest expected one.
    always @(posedge clk) begin : check_records
        t_swing_rec got;
        t_swing_rec want;
        if (rst_n && pop && !empty) begin
            got.position     = position_out;
            got.marker_valid = marker_valid_out;
            got.marker       = marker_out;
            got.turning      = turning_out;
            got.run_end      = run_end_out;
            if (pending_records.size() == 0) begin
                report_mismatch($sformatf("unexpected record pos=%0d mv=%0b mk=%0d tp=%0d end=%0b",
                                          got.position, got.marker_valid, got.marker,
                                          got.turning, got.run_end));
            end else begin
                want = pending_records.pop_front();
                if (got.position !== want.position || got.marker_valid !== want.marker_valid ||
                    got.marker !== want.marker || got.turning !== want.turning ||
                    got.run_end !== want.run_end) begin
                    report_mismatch($sformatf(
                        "expected pos=%0d mv=%0b mk=%0d tp=%0d end=%0b, got pos=%0d mv=%0b mk=%0d tp=%0d end=%0b",
                        want.position, want.marker_valid, want.marker, want.turning,
                        want.run_end, got.position, got.marker_valid, got.marker,
                        got.turning, got.run_end));
                end
            end
        end
    end

    // Ends the run when neither side has moved an item for too long.
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_swings();
        test_extreme_prices();
        test_zero_threshold();
        test_max_threshold();
        test_unmapped_register();

        test_random_traffic(0, 0, 32'($urandom_range(1, 1 << 18)), 50);
        test_random_traffic(81, 0, 32'd0, 50);
        test_pause_for_drain();
        test_random_traffic(0, 81, 32'h7FFF_FFFF, 50);
        test_random_traffic(14, 14, $urandom, 50);

        settle();
        if (pending_records.size() != 0) begin
            report_mismatch($sformatf("%0d expected records never arrived",
                                      pending_records.size()));
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
